>>> rtl/maf_pkg.sv
// Shared types and constants for the moving average filter.
// Used by the channel interfaces and by the top level; no dependencies.
package maf_pkg;

  localparam int unsigned SampleW  = 16;  // sample and average width
  localparam int unsigned IndexW   = 16;  // series index width
  localparam int unsigned WinLenW  = 7;   // window length register width

  localparam logic [IndexW-1:0] IndexMax = {IndexW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_REBUILD,
    ST_DIVIDE,
    ST_EMIT
  } maf_state_e;

endpackage

>>> rtl/maf_if.sv
// Valid/ready channel interfaces of the moving average filter:
// sample input, result output and window length write channel.
// Depends on maf_pkg for the field widths.
interface maf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [maf_pkg::SampleW-1:0]   sample;
  logic                                 last_of_series;

  modport source (output valid, output sample, output last_of_series, input ready);
  modport sink   (input valid, input sample, input last_of_series, output ready);
endinterface

interface maf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [maf_pkg::SampleW-1:0]   average;
  logic        [maf_pkg::IndexW-1:0]    center_index;

  modport source (output valid, output average, output center_index, input ready);
  modport sink   (input valid, input average, input center_index, output ready);
endinterface

interface maf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic        [maf_pkg::WinLenW-1:0]   window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

>>> rtl/moving_average_filter.sv
// Moving average filter: ring store of recent samples, running window sum and a
// bit-serial restoring divider. Depends on maf_pkg and the interfaces in maf_if.sv.
// A sample that completes a window goes through UPDATE, DIVIDE and EMIT, the divider
// giving one quotient bit per cycle; EMIT holds while the output is stalled. A sample
// that gives no result returns to IDLE after UPDATE. The first sample after a length
// write rebuilds the sum in REBUILD. Reset clears counts and sum and sets length 1.
module moving_average_filter #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  maf_in_if.sink              in_chan_i,
  maf_out_if.source           out_chan_o,
  maf_cfg_if.sink             cfg_chan_i
);

  localparam int unsigned SW   = maf_pkg::SampleW;
  localparam int unsigned IW   = maf_pkg::IndexW;
  localparam int unsigned PtrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW = SW + $clog2(MAX_WINDOW);
  localparam int unsigned DcW  = $clog2(SumW);

  localparam logic [LW:0]   MaxWide  = (LW+1)'(MAX_WINDOW);
  localparam logic [8:0]    MaxLen9  = 9'(MAX_WINDOW);
  localparam logic [DcW-1:0] DivLast = DcW'(SumW - 1);

  // step back 'off' entries from ring position p (1 <= off <= MAX_WINDOW)
  function automatic logic [PtrW-1:0] ring_back(input logic [PtrW-1:0] p,
                                                input logic [LW:0]     off);
    logic [LW:0] t;
    t = (LW+1)'(p) + MaxWide - off;
    if (t >= MaxWide) t = t - MaxWide;
    return PtrW'(t);
  endfunction

  maf_pkg::maf_state_e state_q, state_d;

  logic [maf_pkg::WinLenW-1:0] wl_q;
  logic                        dirty_q, dirty_d;
  logic [PtrW-1:0]             wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]             base_q, base_d;
  logic [IW-1:0]               seen_q, seen_d;
  logic signed [SumW-1:0]      sum_q, sum_d;
  logic signed [SumW-1:0]      acc_q, acc_d;
  logic [LW-1:0]               cnt_q, cnt_d;
  logic [LW-1:0]               span_q, span_d;
  logic                        prod_q, prod_d;

  logic signed [SW-1:0]        smp_q, smp_d;
  logic                        last_q, last_d;
  logic [LW-1:0]               len_q, len_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic [IW-1:0]               cen_q, cen_d;

  logic [SumW-1:0]             dvd_q, dvd_d;
  logic [LW-1:0]               rem_q, rem_d;
  logic                        neg_q, neg_d;
  logic [DcW-1:0]              dcnt_q, dcnt_d;

  logic                        out_valid_q, out_valid_d;
  logic signed [SW-1:0]        avg_q, avg_d;
  logic [IW-1:0]               cidx_q, cidx_d;

  logic [SW-1:0]               ring_mem [MAX_WINDOW];
  logic signed [SW-1:0]        rd_q;
  logic [PtrW-1:0]             rd_addr;
  logic                        wr_en;

  logic                        in_fire, out_fire, cfg_fire;
  logic [8:0]                  wl9, eff9;
  logic [LW-1:0]               len_eff;
  logic [IW-1:0]               seen_next;
  logic                        full_old, produce;
  logic signed [SumW-1:0]      sum_inc, sum_total;
  logic                        rebuild_done, div_done, emit_go;
  logic [LW:0]                 div_trial;
  logic                        div_ge;
  logic [IW-1:0]               quot;

  assign in_chan_i.ready  = (state_q == maf_pkg::ST_IDLE);
  assign cfg_chan_i.ready = 1'b1;
  assign out_chan_o.valid        = out_valid_q;
  assign out_chan_o.average      = avg_q;
  assign out_chan_o.center_index = cidx_q;

  assign in_fire  = in_chan_i.valid & in_chan_i.ready;
  assign out_fire = out_valid_q & out_chan_o.ready;
  assign cfg_fire = cfg_chan_i.valid;

  // clamp the register to 1..MAX_WINDOW
  assign wl9     = 9'(wl_q);
  assign eff9    = (wl9 == '0) ? 9'd1 : ((wl9 > MaxLen9) ? MaxLen9 : wl9);
  assign len_eff = LW'(eff9);

  assign seen_next = (seen_q == maf_pkg::IndexMax) ? seen_q : seen_q + 1'b1;
  assign full_old  = (seen_q >= IW'(len_q));
  assign produce   = (seen_next >= IW'(len_q));
  assign sum_inc   = sum_q + SumW'(smp_q) - (full_old ? SumW'(rd_q) : '0);
  assign sum_total = acc_q + SumW'(rd_q);

  assign rebuild_done = (cnt_q == span_q);
  assign div_done     = (dcnt_q == DivLast);
  assign emit_go      = !out_valid_q || out_chan_o.ready;

  assign div_trial = {rem_q, dvd_q[SumW-1]};
  assign div_ge    = (div_trial >= (LW+1)'(len_q));
  assign quot      = IW'(dvd_q);

  always_comb begin
    unique case (state_q)
      maf_pkg::ST_IDLE:    rd_addr = ring_back(wr_ptr_q, (LW+1)'(len_eff));
      maf_pkg::ST_REBUILD: rd_addr = ring_back(base_q, (LW+1)'(cnt_q) + 1'b1);
      default:             rd_addr = wr_ptr_q;
    endcase
  end

  assign wr_en = (state_q == maf_pkg::ST_UPDATE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_ptr_q] <= smp_q;
    end
    rd_q <= ring_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      maf_pkg::ST_IDLE: begin
        if (in_fire) state_d = maf_pkg::ST_UPDATE;
      end
      maf_pkg::ST_UPDATE: begin
        if (dirty_q)      state_d = maf_pkg::ST_REBUILD;
        else if (produce) state_d = maf_pkg::ST_DIVIDE;
        else              state_d = maf_pkg::ST_IDLE;
      end
      maf_pkg::ST_REBUILD: begin
        if (rebuild_done) state_d = prod_q ? maf_pkg::ST_DIVIDE : maf_pkg::ST_IDLE;
      end
      maf_pkg::ST_DIVIDE: begin
        if (div_done) state_d = maf_pkg::ST_EMIT;
      end
      maf_pkg::ST_EMIT: begin
        if (emit_go) state_d = maf_pkg::ST_IDLE;
      end
      default: state_d = maf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    dirty_d  = dirty_q;
    wr_ptr_d = wr_ptr_q;
    base_d   = base_q;
    seen_d   = seen_q;
    sum_d    = sum_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    span_d   = span_q;
    prod_d   = prod_q;
    smp_d    = smp_q;
    last_d   = last_q;
    len_d    = len_q;
    idx_d    = idx_q;
    cen_d    = cen_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    dcnt_d   = dcnt_q;
    avg_d    = avg_q;
    cidx_d   = cidx_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;

    unique case (state_q)
      maf_pkg::ST_IDLE: begin
        if (in_fire) begin
          smp_d  = in_chan_i.sample;
          last_d = in_chan_i.last_of_series;
          len_d  = len_eff;
          idx_d  = seen_q;
        end
      end
      maf_pkg::ST_UPDATE: begin
        base_d   = (wr_ptr_q == PtrW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_q + 1'b1;
        wr_ptr_d = last_q ? '0 : base_d;
        seen_d   = last_q ? '0 : seen_next;
        prod_d   = produce;
        cen_d    = idx_q - IW'((len_q - 1'b1) >> 1);
        acc_d    = '0;
        cnt_d    = '0;
        span_d   = (seen_next < IW'(len_q)) ? LW'(seen_next) : len_q;
        if (!dirty_q) begin
          sum_d  = last_q ? '0 : sum_inc;
          neg_d  = sum_inc[SumW-1];
          dvd_d  = sum_inc[SumW-1] ? unsigned'(-sum_inc) : unsigned'(sum_inc);
          rem_d  = '0;
          dcnt_d = '0;
        end
      end
      maf_pkg::ST_REBUILD: begin
        // reads are registered, so each add uses the data read in the cycle before
        if (cnt_q != '0) acc_d = sum_total;
        if (rebuild_done) begin
          sum_d   = last_q ? '0 : sum_total;
          dirty_d = 1'b0;
          neg_d   = sum_total[SumW-1];
          dvd_d   = sum_total[SumW-1] ? unsigned'(-sum_total) : unsigned'(sum_total);
          rem_d   = '0;
          dcnt_d  = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      maf_pkg::ST_DIVIDE: begin
        rem_d  = div_ge ? LW'(div_trial - (LW+1)'(len_q)) : LW'(div_trial);
        dvd_d  = {dvd_q[SumW-2:0], div_ge};
        dcnt_d = dcnt_q + 1'b1;
      end
      maf_pkg::ST_EMIT: begin
        if (emit_go) begin
          avg_d       = neg_q ? signed'(-quot) : signed'(quot);
          cidx_d      = cen_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    // a window length write invalidates the running sum
    if (cfg_fire) dirty_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= maf_pkg::ST_IDLE;
      wl_q        <= maf_pkg::WinLenW'(1);
      dirty_q     <= 1'b0;
      wr_ptr_q    <= '0;
      seen_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_fire) wl_q <= cfg_chan_i.window_length;
      dirty_q     <= dirty_d;
      wr_ptr_q    <= wr_ptr_d;
      seen_q      <= seen_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    acc_q  <= acc_d;
    span_q <= span_d;
    prod_q <= prod_d;
    smp_q  <= smp_d;
    last_q <= last_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    cen_q  <= cen_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    avg_q  <= avg_d;
    cidx_q <= cidx_d;
  end

endmodule

>>> test/tb.sv
// Testbench for moving_average_filter: directed table followed by random series.
// Predicts each average or takes it from the table; checks every result in order.
// Depends on maf_pkg and the channel interfaces in rtl/maf_if.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import maf_pkg::*;

  localparam int unsigned MaxWindow    = 64;
  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned RandomItems  = 800;
  localparam int unsigned MaxReports   = 10;
  localparam longint     TimeoutNs     = 5_000_000;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  localparam logic [WinLenW-1:0] EdgeLengths [7] = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64,
                                                     7'd65, 7'd127};

  typedef struct packed {
    logic signed [SampleW-1:0] average;
    logic [IndexW-1:0]         center_index;
  } maf_result_t;

  typedef struct packed {
    logic                      set_len;
    logic [WinLenW-1:0]        len;
    logic signed [SampleW-1:0] sample;
    logic                      last;
    logic                      typed;
    logic                      typed_has;
    logic signed [SampleW-1:0] t_avg;
    logic [IndexW-1:0]         t_idx;
  } directed_row_t;

  localparam int unsigned DirectedRows = 21;
  localparam directed_row_t DirectedTable [DirectedRows] = '{
    // full scale with length one, then a new series
    '{1'b0, 7'd0,   SampleMax,  1'b0, 1'b1, 1'b1, SampleMax, 16'd0},
    '{1'b0, 7'd0,   SampleMin,  1'b0, 1'b1, 1'b1, SampleMin, 16'd1},
    '{1'b0, 7'd0,   16'sd0,     1'b1, 1'b1, 1'b1, 16'sd0,    16'd2},
    '{1'b0, 7'd0,   -16'sd1,    1'b0, 1'b1, 1'b1, -16'sd1,   16'd0},
    // length zero acts as one, then length three
    '{1'b1, 7'd0,   16'sd5,     1'b1, 1'b1, 1'b1, 16'sd5,    16'd1},
    '{1'b1, 7'd3,   16'sd7,     1'b0, 1'b1, 1'b0, 16'sd0,    16'd0},
    '{1'b0, 7'd0,   -16'sd8,    1'b0, 1'b1, 1'b0, 16'sd0,    16'd0},
    '{1'b0, 7'd0,   16'sd2,     1'b0, 1'b1, 1'b1, 16'sd0,    16'd1},
    '{1'b0, 7'd0,   SampleMin,  1'b0, 1'b0, 1'b0, 16'sd0,    16'd0},
    // length above the store clamps to the store; too few samples here
    '{1'b1, 7'd127, SampleMax,  1'b1, 1'b1, 1'b0, 16'sd0,    16'd0},
    // even length
    '{1'b1, 7'd4,   16'sd1,     1'b0, 1'b1, 1'b0, 16'sd0,    16'd0},
    '{1'b0, 7'd0,   16'sd2,     1'b0, 1'b1, 1'b0, 16'sd0,    16'd0},
    '{1'b0, 7'd0,   16'sd3,     1'b0, 1'b1, 1'b0, 16'sd0,    16'd0},
    '{1'b0, 7'd0,   16'sd4,     1'b0, 1'b1, 1'b1, 16'sd2,    16'd2},
    '{1'b0, 7'd0,   -16'sd3,    1'b0, 1'b0, 1'b0, 16'sd0,    16'd0},
    // length changes inside the series
    '{1'b1, 7'd2,   16'sd9,     1'b0, 1'b0, 1'b0, 16'sd0,    16'd0},
    '{1'b1, 7'd7,   16'sd1,     1'b0, 1'b0, 1'b0, 16'sd0,    16'd0},
    '{1'b0, 7'd0,   -16'sd7,    1'b1, 1'b0, 1'b0, 16'sd0,    16'd0},
    // negative sum truncates toward zero
    '{1'b1, 7'd2,   -16'sd3,    1'b0, 1'b1, 1'b0, 16'sd0,    16'd0},
    '{1'b0, 7'd0,   -16'sd4,    1'b1, 1'b1, 1'b1, -16'sd3,   16'd1},
    '{1'b1, 7'd1,   SampleMin,  1'b1, 1'b1, 1'b1, SampleMin, 16'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  maf_in_if  in_chan ();
  maf_out_if out_chan ();
  maf_cfg_if cfg_chan ();

  moving_average_filter u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  // Bench copy of the filter state
  logic signed [SampleW-1:0] ring [MaxWindow];
  int unsigned               seen_count = 0;
  int unsigned               ring_wr    = 0;
  logic [WinLenW-1:0]        win_len    = 7'd1;

  maf_result_t expected_q [$];
  int unsigned mismatches = 0;
  bit          idle_on    = 1'b1;

  always #(ClkPeriod / 2) clk = ~clk;

  initial begin
    #TimeoutNs;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned active_length();
    if (win_len == 0) return 1;
    if (win_len > MaxWindow) return MaxWindow;
    return int'(win_len);
  endfunction

  function automatic bit predict_average(input logic signed [SampleW-1:0] smp, input bit last,
                                         output maf_result_t res);
    int unsigned win;
    int unsigned idx;
    int unsigned k;
    int          sum;
    bit          produced;
    win = active_length();
    idx = (seen_count > IndexMax) ? int'(IndexMax) : seen_count;
    ring[ring_wr] = smp;
    ring_wr = (ring_wr + 1) % MaxWindow;
    if (seen_count < IndexMax) seen_count++;
    produced = (seen_count >= win);
    res = '0;
    if (produced) begin
      sum = 0;
      for (k = 0; k < win; k++) begin
        sum += int'(ring[(ring_wr + MaxWindow - 1 - k) % MaxWindow]);
      end
      res.average      = SampleW'(sum / int'(win));
      res.center_index = IndexW'(idx - (win - 1) / 2);
    end
    if (last) begin
      seen_count = 0;
      ring_wr    = 0;
    end
    return produced;
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample(input int unsigned style);
    int unsigned r;
    // styles 4 and 5 hold the window near full scale
    if (style == 4 && $urandom_range(15, 0) != 0) return SampleMax;
    if (style == 5 && $urandom_range(15, 0) != 0) return SampleMin;
    r = $urandom_range(7, 0);
    if (r == 0) return SampleMax;
    if (r == 1) return SampleMin;
    if (r == 2) return SampleW'($urandom_range(6, 0)) - 16'sd3;
    return SampleW'($urandom);
  endfunction

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // let a sample with no result finish in the block
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_window_length(input logic [WinLenW-1:0] len);
    wait_idle();
    cfg_chan.valid         <= 1'b1;
    cfg_chan.window_length <= len;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    win_len = len;
  endtask

  task automatic send_sample(input logic signed [SampleW-1:0] smp, input bit last,
                             input bit use_typed, input bit typed_has,
                             input maf_result_t typed_res);
    int unsigned gap;
    bit          has_result;
    maf_result_t predicted;
    gap = idle_on ? $urandom_range(16, 0) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.sample         <= smp;
    in_chan.last_of_series <= last;
    do @(posedge clk); while (!in_chan.ready);
    has_result = predict_average(smp, last, predicted);
    if (use_typed) begin
      if (typed_has) expected_q.push_back(typed_res);
    end else if (has_result) begin
      expected_q.push_back(predicted);
    end
  endtask

  // Result side: with idle_on, stall a random number of cycles before each request
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = idle_on ? $urandom_range(16, 0) : 0;
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  always @(posedge clk) begin : result_monitor
    maf_result_t got;
    maf_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.average      = out_chan.average;
      got.center_index = out_chan.center_index;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result: average=%0d center_index=%0d",
                   got.average, got.center_index);
        end
      end else begin
        want = expected_q.pop_front();
        if (got.average !== want.average || got.center_index !== want.center_index) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("mismatch: average exp %0d got %0d, center_index exp %0d got %0d",
                     want.average, got.average, want.center_index, got.center_index);
          end
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t row;
    maf_result_t   typed_res;
    logic [WinLenW-1:0] len;
    int unsigned   random_sent;
    int unsigned   n_series;
    int unsigned   ser_len;
    int unsigned   change_at;
    int unsigned   style;
    int unsigned   win;
    int unsigned   i;
    int unsigned   s;

    in_chan.valid          <= 1'b0;
    in_chan.sample         <= '0;
    in_chan.last_of_series <= 1'b0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.window_length <= '0;
    rst_n                  <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DirectedRows; i++) begin
      row = DirectedTable[i];
      if (row.set_len) write_window_length(row.len);
      typed_res.average      = row.t_avg;
      typed_res.center_index = row.t_idx;
      send_sample(row.sample, row.last, row.typed, row.typed_has, typed_res);
    end

    random_sent = 0;
    while (random_sent < RandomItems) begin
      case ($urandom_range(2, 0))
        0: len = EdgeLengths[$urandom_range(6, 0)];
        1: len = WinLenW'(2 * $urandom_range(31, 0) + 1);
        default: len = WinLenW'($urandom_range(127, 0));
      endcase
      write_window_length(len);
      idle_on  = ($urandom_range(3, 0) != 0);
      n_series = $urandom_range(3, 1);
      for (s = 0; s < n_series; s++) begin
        win     = active_length();
        ser_len = ($urandom_range(4, 0) == 0) ? $urandom_range(win, 1)
                                              : win + $urandom_range(24, 0);
        style     = $urandom_range(5, 0);
        change_at = ($urandom_range(5, 0) == 0) ? $urandom_range(ser_len, 1) : ser_len;
        for (i = 0; i < ser_len; i++) begin
          if (i == change_at) write_window_length(WinLenW'($urandom_range(127, 0)));
          send_sample(pick_sample(style), i == ser_len - 1, 1'b0, 1'b0, '0);
          random_sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
